[rtl/dslpd_pkg.sv]
package dslpd_pkg;

  localparam logic [3:0] COL_NAME   = 4'd2;
  localparam logic [3:0] COL_READS  = 4'd3;
  localparam logic [3:0] COL_WRITES = 4'd7;
  localparam logic [3:0] COL_MAX    = 4'd15;

  localparam logic [7:0] CHAR_NL   = 8'd10;
  localparam logic [7:0] CHAR_TAB  = 8'd9;
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_SP   = 8'd32;
  localparam logic [7:0] CHAR_ZERO = 8'd48;

  // "Combined", first character in the low byte.
  localparam logic [63:0] COMBINED_LABEL = 64'h64656e69626d6f43;
  localparam int unsigned LABEL_BYTES = 8;

  typedef struct packed {
    logic step;
    logic clear;
  } parse_ctrl_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SP) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

[rtl/dslpd_parser.sv]
module dslpd_parser #(
  parameter int unsigned NAME_BYTES = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dslpd_pkg::parse_ctrl_t    ctrl_i,
  input  logic [7:0]                char_i,
  output logic [NAME_BYTES*8-1:0]   name_o,
  output logic                      name_nz_o,
  output logic [63:0]               rd_acc_o,
  output logic [63:0]               wr_acc_o
);

  localparam int unsigned LW = $clog2(NAME_BYTES);

  logic [3:0]              col_q, col_d;
  logic                    gap_q, gap_d;
  logic [NAME_BYTES*8-1:0] name_q, name_d;
  logic [LW-1:0]           len_q, len_d;
  logic [63:0]             rd_q, rd_d, wr_q, wr_d;
  logic [63:0]             digit;

  assign digit = 64'(char_i) - 64'(dslpd_pkg::CHAR_ZERO);

  always_comb begin
    col_d  = col_q;
    gap_d  = gap_q;
    name_d = name_q;
    len_d  = len_q;
    rd_d   = rd_q;
    wr_d   = wr_q;
    if (ctrl_i.clear) begin
      col_d  = '0;
      gap_d  = 1'b1;
      name_d = '0;
      len_d  = '0;
      rd_d   = '0;
      wr_d   = '0;
    end else if (ctrl_i.step && (char_i != dslpd_pkg::CHAR_NL)) begin
      if (dslpd_pkg::is_space(char_i)) begin
        if (!gap_q) begin
          if (col_q != dslpd_pkg::COL_MAX) begin
            col_d = col_q + 4'd1;
          end
          gap_d = 1'b1;
        end
      end else begin
        gap_d = 1'b0;
        if (col_q == dslpd_pkg::COL_NAME) begin
          if ((char_i != 8'd0) && (LW'(len_q) != LW'(NAME_BYTES - 1))) begin
            name_d[len_q*8 +: 8] = char_i;
            len_d = len_q + LW'(1);
          end
        end else if (col_q == dslpd_pkg::COL_READS) begin
          rd_d = {rd_q[60:0], 3'b000} + {rd_q[62:0], 1'b0} + digit;
        end else if (col_q == dslpd_pkg::COL_WRITES) begin
          wr_d = {wr_q[60:0], 3'b000} + {wr_q[62:0], 1'b0} + digit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      gap_q  <= 1'b1;
      name_q <= '0;
      len_q  <= '0;
      rd_q   <= '0;
      wr_q   <= '0;
    end else begin
      col_q  <= col_d;
      gap_q  <= gap_d;
      name_q <= name_d;
      len_q  <= len_d;
      rd_q   <= rd_d;
      wr_q   <= wr_d;
    end
  end

  assign name_o    = name_q;
  assign name_nz_o = (len_q != '0);
  assign rd_acc_o  = rd_q;
  assign wr_acc_o  = wr_q;

endmodule

[rtl/dslpd_table.sv]
module dslpd_table #(
  parameter int unsigned MAX_DEVICES = 32,
  parameter int unsigned NAME_BYTES  = 32,
  parameter int unsigned IW          = 5
) (
  input  logic                    clk_i,
  input  logic [IW-1:0]           name_addr_i,
  input  logic                    name_we_i,
  input  logic [NAME_BYTES*8-1:0] name_wdata_i,
  output logic [NAME_BYTES*8-1:0] name_rdata_o,
  input  logic [IW-1:0]           prev_addr_i,
  input  logic                    prev_we_i,
  input  logic [127:0]            prev_wdata_i,
  output logic [127:0]            prev_rdata_o
);

  logic [NAME_BYTES*8-1:0] name_mem [MAX_DEVICES];
  logic [127:0]            prev_mem [MAX_DEVICES];

  always_ff @(posedge clk_i) begin
    if (name_we_i) begin
      name_mem[name_addr_i] <= name_wdata_i;
    end
    name_rdata_o <= name_mem[name_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we_i) begin
      prev_mem[prev_addr_i] <= prev_wdata_i;
    end
    prev_rdata_o <= prev_mem[prev_addr_i];
  end

endmodule

[rtl/disk_stat_line_parser_delta_core.sv]
// A character that ends no line is accepted while the core is idle, and one can follow every
// cycle. A line end searches the device table entry by entry (memory read, then compare), then
// reads and writes back the stored totals. A new name is compared with all N stored devices;
// a match ends the search early. Output stalls hold the core, and at a poll end a second search
// follows for the combined entry. One transaction is in flight at a time. Reset clears the
// parser and the slot count; the table memories are only read once allocated.
module disk_stat_line_parser_delta_core #(
  parameter int unsigned MAX_DEVICES = 32,
  parameter int unsigned NAME_BYTES  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        poll_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  slot_o,
  output logic        is_combined_o,
  output logic signed [63:0] reads_delta_o,
  output logic signed [63:0] writes_delta_o,
  output logic        table_full_o,
  output logic        last_o
);

  localparam int unsigned IW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned SUW = $clog2(MAX_DEVICES + 1);
  localparam int unsigned NW  = NAME_BYTES * 8;
  localparam int unsigned LABEL_BYTES_C = dslpd_pkg::LABEL_BYTES;
  localparam int unsigned LBL = (LABEL_BYTES_C < NAME_BYTES - 1) ? LABEL_BYTES_C
                                                                 : NAME_BYTES - 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LINE, S_START, S_RD, S_CMP, S_MISS, S_PRD, S_EMIT
  } state_e;

  state_e              state_q;
  logic                upd_q;
  logic [IW-1:0]       idx_q, slot_q;
  logic                comb_q, pe_q, quiet_q, first_poll_q;
  logic [SUW-1:0]      slots_used_q;
  logic [63:0]         sum_rd_q, sum_wr_q;
  logic                res_full_q;
  logic [63:0]         res_rd_q, res_wr_q;
  logic [IW+4:0]       slot_ext;

  dslpd_pkg::parse_ctrl_t pctrl;
  logic [NW-1:0]       name_buf, label_key, key;
  logic                name_nz;
  logic [63:0]         rd_acc, wr_acc;
  logic                name_we, prev_we;
  logic [IW-1:0]       name_addr, prev_addr;
  logic [NW-1:0]       name_rdata;
  logic [127:0]        prev_rdata, prev_wdata;
  logic                in_acc, out_free, full_now;
  logic [SUW-1:0]      idx_next;
  logic [63:0]         rd_dl, wr_dl;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign full_now   = (slots_used_q == SUW'(MAX_DEVICES));
  assign idx_next   = SUW'(idx_q) + SUW'(1);

  always_comb begin
    label_key = '0;
    for (int i = 0; i < LBL; i++) begin
      label_key[i*8 +: 8] = dslpd_pkg::COMBINED_LABEL[i*8 +: 8];
    end
  end

  assign key = comb_q ? label_key : name_buf;

  assign pctrl.step  = in_acc;
  assign pctrl.clear = ((state_q == S_LINE) && !name_nz)
                    || ((state_q == S_EMIT) && out_free && !comb_q);

  dslpd_parser #(.NAME_BYTES(NAME_BYTES)) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pctrl),
    .char_i    (char_in_i),
    .name_o    (name_buf),
    .name_nz_o (name_nz),
    .rd_acc_o  (rd_acc),
    .wr_acc_o  (wr_acc)
  );

  assign name_we   = (state_q == S_MISS) && !full_now;
  assign name_addr = (state_q == S_MISS) ? slots_used_q[IW-1:0] : idx_q;
  assign prev_addr = (state_q == S_MISS) ? slots_used_q[IW-1:0] : slot_q;
  assign prev_we   = name_we || upd_q;
  assign prev_wdata = upd_q ? {wr_acc, rd_acc} : '0;
  assign rd_dl     = rd_acc - prev_rdata[63:0];
  assign wr_dl     = wr_acc - prev_rdata[127:64];

  dslpd_table #(
    .MAX_DEVICES(MAX_DEVICES), .NAME_BYTES(NAME_BYTES), .IW(IW)
  ) u_table (
    .clk_i        (clk_i),
    .name_addr_i  (name_addr),
    .name_we_i    (name_we),
    .name_wdata_i (key),
    .name_rdata_o (name_rdata),
    .prev_addr_i  (prev_addr),
    .prev_we_i    (prev_we),
    .prev_wdata_i (prev_wdata),
    .prev_rdata_o (prev_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      upd_q        <= 1'b0;
      idx_q        <= '0;
      slot_q       <= '0;
      comb_q       <= 1'b0;
      pe_q         <= 1'b0;
      quiet_q      <= 1'b0;
      first_poll_q <= 1'b1;
      slots_used_q <= '0;
      sum_rd_q     <= '0;
      sum_wr_q     <= '0;
      res_full_q   <= 1'b0;
      res_rd_q     <= '0;
      res_wr_q     <= '0;
      out_valid_o  <= 1'b0;
      slot_o       <= '0;
      is_combined_o <= 1'b0;
      reads_delta_o <= '0;
      writes_delta_o <= '0;
      table_full_o <= 1'b0;
      last_o       <= 1'b0;
    end else begin
      upd_q <= (state_q == S_PRD);
      if ((state_q == S_EMIT) && !upd_q && out_free && !quiet_q) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pe_q    <= poll_end_i;
            quiet_q <= first_poll_q;
            comb_q  <= 1'b0;
            if ((char_in_i == dslpd_pkg::CHAR_NL) || poll_end_i) begin
              state_q <= S_LINE;
            end
          end
        end
        S_LINE: begin
          if (name_nz) begin
            state_q <= S_START;
          end else if (pe_q) begin
            comb_q  <= 1'b1;
            state_q <= S_START;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_START: begin
          idx_q   <= '0;
          state_q <= (slots_used_q == '0) ? S_MISS : S_RD;
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (name_rdata == key) begin
            slot_q     <= idx_q;
            res_full_q <= 1'b0;
            state_q    <= comb_q ? S_EMIT : S_PRD;
          end else if (idx_next < slots_used_q) begin
            idx_q   <= idx_next[IW-1:0];
            state_q <= S_RD;
          end else begin
            state_q <= S_MISS;
          end
        end
        S_MISS: begin
          if (!full_now) begin
            slot_q       <= slots_used_q[IW-1:0];
            slots_used_q <= slots_used_q + SUW'(1);
            res_full_q   <= 1'b0;
            state_q      <= comb_q ? S_EMIT : S_PRD;
          end else begin
            res_full_q <= 1'b1;
            res_rd_q   <= '0;
            res_wr_q   <= '0;
            state_q    <= S_EMIT;
          end
        end
        S_PRD: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (upd_q) begin
            res_rd_q <= rd_dl;
            res_wr_q <= wr_dl;
            sum_rd_q <= sum_rd_q + rd_dl;
            sum_wr_q <= sum_wr_q + wr_dl;
          end else if (out_free) begin
            if (!quiet_q) begin
              is_combined_o <= comb_q;
              table_full_o  <= res_full_q;
              last_o        <= comb_q || !pe_q;
              if (comb_q) begin
                slot_o         <= '0;
                reads_delta_o  <= sum_rd_q;
                writes_delta_o <= sum_wr_q;
              end else begin
                slot_o         <= res_full_q ? 5'd0 : slot_ext[4:0];
                reads_delta_o  <= res_rd_q;
                writes_delta_o <= res_wr_q;
              end
            end
            if (comb_q) begin
              sum_rd_q     <= '0;
              sum_wr_q     <= '0;
              first_poll_q <= 1'b0;
              state_q      <= S_IDLE;
            end else if (pe_q) begin
              comb_q  <= 1'b1;
              state_q <= S_START;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign slot_ext = {5'b00000, slot_q};

  a_slots_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_used_q <= SUW'(MAX_DEVICES))
    else $error("slot count beyond table size");

  a_combined_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_combined_o) |-> (slot_o == 5'd0) && last_o)
    else $error("combined result with slot or without last");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o && !is_combined_o) |->
      (reads_delta_o == 64'sd0) && (writes_delta_o == 64'sd0) && (slot_o == 5'd0))
    else $error("dropped line carries data");

  a_busy_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (poll_end_i || (char_in_i == dslpd_pkg::CHAR_NL))) |=> in_stall_o)
    else $error("line end not processed");

endmodule
